### rtl/mfb_pkg.sv
// Shared package for the monochrome frame buffer blitter.
// Geometry constants, command and raster-op codes, request/result and ALU structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfb_pkg;

	// frame geometry
	localparam int WIDTH     = 400;
	localparam int HEIGHT    = 240;
	localparam int ROW_BYTES = (WIDTH + 7) / 8;
	localparam int DEPTH     = HEIGHT * ROW_BYTES;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int ROW_W     = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
	localparam int COL_W     = $clog2(ROW_BYTES);
	localparam int XW        = 10;   // holds WIDTH itself
	localparam int MAX_RUN   = 24;

	// commands
	localparam logic [1:0] CMD_BLIT  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_TAKE  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// raster ops
	localparam logic [1:0] ROP_OR   = 2'd0;
	localparam logic [1:0] ROP_XOR  = 2'd1;
	localparam logic [1:0] ROP_ANDN = 2'd2;
	localparam logic [1:0] ROP_BAD  = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [8:0]  x;
		logic [7:0]  y;
		logic [4:0]  run_length;
		logic [23:0] pattern;
		logic [1:0]  raster_op;
		logic        solid_fill;
	} req_t;

	typedef struct packed {
		logic accepted;
		logic pixel;
		logic row_dirty;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
		logic [1:0]        rop;
		logic [7:0]        mem_byte;
		logic [7:0]        src_byte;
	} alu_in_t;

	typedef struct packed {
		logic [ADDR_W-1:0] sum;
		logic [7:0]        new_byte;
	} alu_out_t;

endpackage

`default_nettype wire

### rtl/mono_framebuffer_blitter_unit.sv
// Top level of the monochrome frame buffer blitter: sequencer, frame byte store,
// row dirty flags. Depends on mfb_pkg and mfb_alu.
`timescale 1ns / 1ps
`default_nettype none

// One request is taken when start is high and busy is low; busy stays high until
// the request is finished, and its result is shown on result for exactly one cycle
// with done high. The receiver cannot stall: a result must be captured in its cycle.
// A blit touches N = 1..4 frame bytes; each byte is one read and one write on the
// single-port frame store, addresses stepped by the shared adder. Clear screen
// sweeps the whole store, one byte written per cycle. After reset the block runs
// the same sweep (DEPTH = 12000 bytes at 400x240) with busy high and no result,
// filling the store with ones and setting every dirty flag.
// Pixel x of a row lives in bit (WIDTH-1-x)%8 of byte (WIDTH-1-x)/8 of that row.

module mono_framebuffer_blitter_unit
	import mfb_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_RD     = 3'd2;
	localparam logic [2:0] S_MOD    = 3'd3;
	localparam logic [2:0] S_SWEEP  = 3'd4;

	logic [2:0]        st_q;
	logic              fill_q;      // sweep value for dirty flags: 1 after reset
	logic [ADDR_W-1:0] addr_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [1:0]        cnt_q;
	logic              done_q;
	rsp_t              rsp_q;

	// payload
	req_t              req_q;
	logic [31:0]       src_q;
	logic [1:0]        last_q;
	logic [2:0]        bitsel_q;
	logic [7:0]        rdata_q;
	logic              dflag_q;

	// storage
	logic [7:0] frame_mem [DEPTH];
	logic       dirty_mem [HEIGHT];

	alu_in_t  ain;
	alu_out_t aout;

	mfb_alu u_alu (
		.ain  (ain),
		.aout (aout)
	);

	// ---- request decode (from latched request) ----
	logic [XW-1:0]     x_w, len_w, end_w, pos, pix_pos;
	logic              x_in, y_in, len_ok, blit_ok;
	logic [5:0]        nb_sum;
	logic [2:0]        nbytes;
	logic [31:0]       mask, src;
	logic [ADDR_W-1:0] base;
	logic [ROW_W-1:0]  yrow;

	always_comb begin
		x_w     = {1'b0, req_q.x};
		len_w   = XW'(req_q.run_length);
		end_w   = x_w + len_w;
		x_in    = x_w < XW'(WIDTH);
		y_in    = {1'b0, req_q.y} < 9'(HEIGHT);
		len_ok  = (req_q.run_length != 5'd0) && (req_q.run_length <= 5'(MAX_RUN));
		blit_ok = len_ok && x_in && (end_w <= XW'(WIDTH)) && y_in
			&& (req_q.raster_op != ROP_BAD);
		pos     = XW'(WIDTH) - len_w - x_w;
		pix_pos = XW'(WIDTH - 1) - x_w;
		nb_sum  = 6'(pos[2:0]) + 6'(req_q.run_length) + 6'd7;
		nbytes  = nb_sum[5:3];
		mask    = (32'd1 << req_q.run_length) - 32'd1;
		if (req_q.solid_fill && req_q.raster_op != ROP_XOR) begin
			src = (req_q.raster_op == ROP_ANDN) ? (mask << pos[2:0]) : 32'd0;
		end else begin
			src = ({8'd0, req_q.pattern} & mask) << pos[2:0];
		end
		base = ADDR_W'(req_q.y * ROW_BYTES);
		yrow = req_q.y[ROW_W-1:0];
	end

	// ---- shared adder operand select ----
	always_comb begin
		ain.a        = addr_q;
		ain.b        = '0;
		ain.rop      = req_q.raster_op;
		ain.mem_byte = rdata_q;
		ain.src_byte = src_q[7:0];
		case (st_q)
			S_DECODE: begin
				ain.a = base;
				ain.b = (req_q.cmd == CMD_BLIT) ? ADDR_W'(pos[XW-1:3])
					: ADDR_W'(pix_pos[XW-1:3]);
			end
			S_MOD, S_SWEEP: begin
				ain.b = ADDR_W'(1);
			end
			default: begin
				ain.b = '0;
			end
		endcase
	end

	// ---- store write controls ----
	logic              fr_we;
	logic [7:0]        fr_wd;
	logic              dr_we;
	logic              dr_wd;
	logic [ROW_W-1:0]  dr_addr;

	always_comb begin
		fr_we   = (st_q == S_SWEEP) || (st_q == S_MOD && req_q.cmd == CMD_BLIT);
		fr_wd   = (st_q == S_SWEEP) ? 8'hFF : aout.new_byte;
		dr_we   = 1'b0;
		dr_wd   = 1'b0;
		dr_addr = yrow;
		if (st_q == S_SWEEP) begin
			dr_we   = 1'b1;
			dr_wd   = fill_q;
			dr_addr = row_q;
		end else if (st_q == S_MOD && req_q.cmd == CMD_BLIT && cnt_q == last_q) begin
			dr_we = 1'b1;
			dr_wd = 1'b1;
		end else if (st_q == S_MOD && req_q.cmd == CMD_TAKE) begin
			dr_we = 1'b1;
			dr_wd = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fr_we) begin
			frame_mem[addr_q] <= fr_wd;
		end
		if (st_q == S_RD) begin
			rdata_q <= frame_mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (dr_we) begin
			dirty_mem[dr_addr] <= dr_wd;
		end
		if (st_q == S_RD) begin
			dflag_q <= dirty_mem[yrow];
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start) begin
			req_q <= request;
		end
		if (st_q == S_DECODE) begin
			src_q    <= src;
			last_q   <= 2'(nbytes - 3'd1);
			bitsel_q <= pix_pos[2:0];
		end else if (st_q == S_MOD) begin
			src_q <= src_q >> 8;
		end
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_SWEEP;
			fill_q <= 1'b1;
			addr_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			rsp_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						st_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (req_q.cmd)
						CMD_BLIT: begin
							if (blit_ok) begin
								addr_q <= aout.sum;
								cnt_q  <= '0;
								st_q   <= S_RD;
							end else begin
								rsp_q  <= '0;
								done_q <= 1'b1;
								st_q   <= S_IDLE;
							end
						end
						CMD_READ: begin
							if (x_in && y_in) begin
								addr_q <= aout.sum;
								st_q   <= S_RD;
							end else begin
								rsp_q  <= '0;
								done_q <= 1'b1;
								st_q   <= S_IDLE;
							end
						end
						CMD_TAKE: begin
							if (y_in) begin
								st_q <= S_RD;
							end else begin
								rsp_q  <= '0;
								done_q <= 1'b1;
								st_q   <= S_IDLE;
							end
						end
						default: begin
							// clear screen: sweep the whole store
							addr_q <= '0;
							col_q  <= '0;
							row_q  <= '0;
							fill_q <= 1'b0;
							st_q   <= S_SWEEP;
						end
					endcase
				end
				S_RD: begin
					st_q <= S_MOD;
				end
				S_MOD: begin
					case (req_q.cmd)
						CMD_BLIT: begin
							if (cnt_q == last_q) begin
								rsp_q  <= '{accepted: 1'b1, pixel: 1'b0, row_dirty: 1'b0};
								done_q <= 1'b1;
								st_q   <= S_IDLE;
							end else begin
								cnt_q  <= cnt_q + 2'd1;
								addr_q <= aout.sum;
								st_q   <= S_RD;
							end
						end
						CMD_READ: begin
							rsp_q  <= '{accepted: 1'b1, pixel: rdata_q[bitsel_q],
								row_dirty: 1'b0};
							done_q <= 1'b1;
							st_q   <= S_IDLE;
						end
						default: begin
							rsp_q  <= '{accepted: 1'b1, pixel: 1'b0, row_dirty: dflag_q};
							done_q <= 1'b1;
							st_q   <= S_IDLE;
						end
					endcase
				end
				S_SWEEP: begin
					if (addr_q == ADDR_W'(DEPTH - 1)) begin
						st_q <= S_IDLE;
						if (!fill_q) begin
							rsp_q  <= '{accepted: 1'b1, pixel: 1'b0, row_dirty: 1'b0};
							done_q <= 1'b1;
						end
					end else begin
						addr_q <= aout.sum;
						if (col_q == COL_W'(ROW_BYTES - 1)) begin
							col_q <= '0;
							row_q <= row_q + ROW_W'(1);
						end else begin
							col_q <= col_q + COL_W'(1);
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (st_q != S_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

endmodule

`default_nettype wire

### rtl/mfb_alu.sv
// Shared arithmetic unit: one address adder and one byte raster-op combiner.
// Depends on mfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfb_alu
	import mfb_pkg::*;
(
	input  alu_in_t  ain,
	output alu_out_t aout
);

	always_comb begin
		aout.sum = ain.a + ain.b;
		case (ain.rop)
			ROP_OR:   aout.new_byte = ain.mem_byte | ain.src_byte;
			ROP_XOR:  aout.new_byte = ain.mem_byte ^ ain.src_byte;
			ROP_ANDN: aout.new_byte = ain.mem_byte & ~ain.src_byte;
			default:  aout.new_byte = ain.mem_byte;
		endcase
	end

endmodule

`default_nettype wire

### tb/mono_framebuffer_blitter_unit_test.sv
// Self-checking testbench for mono_framebuffer_blitter_unit: directed and random
// blit / pixel read / dirty take / clear requests checked against a shadow frame.
// Depends on mfb_pkg and the blitter RTL.
`timescale 1ns / 1ps

module mono_framebuffer_blitter_unit_test;
	import mfb_pkg::*;

	// Longest correct quiet spell is a clear plus a request gap, or the power-up sweep;
	// allow several times that.
	localparam int QUIET_LIMIT   = 60000;
	localparam int RANDOM_COUNT  = 450;
	localparam int DRAIN_CYCLES  = 40;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic done;
	rsp_t result;

	// Shadow of the frame store and dirty flags; predicts one result per request.
	class frame_shadow;
		bit [7:0] frame_mem [DEPTH];
		bit       row_flag [HEIGHT];
		rsp_t     rsp_due [$];
		int       mismatches;
		int       results_checked;
		int       blits_done;

		function new();
			foreach (frame_mem[i]) frame_mem[i] = 8'hFF;
			foreach (row_flag[i]) row_flag[i] = 1'b1;
			mismatches = 0;
			results_checked = 0;
			blits_done = 0;
		endfunction

		// Update the shadow for an accepted request and queue its result.
		function void apply_request(req_t r);
			int unsigned xi, yi, len, pos, lead_byte, shift, nb, idx, bitpos, i;
			bit [31:0]   mask, src;
			bit [7:0]    b;
			rsp_t        e;
			e = '0;
			xi = r.x;
			yi = r.y;
			len = r.run_length;
			case (r.cmd)
				CMD_BLIT: begin
					if (len >= 1 && len <= MAX_RUN && xi < WIDTH && xi + len <= WIDTH &&
					    yi < HEIGHT && r.raster_op != ROP_BAD) begin
						// run is right-aligned in the mirrored row
						pos = WIDTH - len - xi;
						lead_byte = pos >> 3;
						shift = pos & 7;
						mask = (32'd1 << len) - 32'd1;
						nb = (shift + len + 7) / 8;
						if (r.solid_fill && r.raster_op != ROP_XOR)
							src = (r.raster_op == ROP_ANDN) ? (mask << shift) : 32'd0;
						else
							src = ({8'd0, r.pattern} & mask) << shift;
						for (i = 0; i < nb; i++) begin
							b = src[8*i +: 8];
							idx = yi * ROW_BYTES + lead_byte + i;
							case (r.raster_op)
								ROP_OR:  frame_mem[idx] = frame_mem[idx] | b;
								ROP_XOR: frame_mem[idx] = frame_mem[idx] ^ b;
								default: frame_mem[idx] = frame_mem[idx] & ~b;
							endcase
						end
						row_flag[yi] = 1'b1;
						e.accepted = 1'b1;
						blits_done++;
					end
				end
				CMD_READ: begin
					if (xi < WIDTH && yi < HEIGHT) begin
						bitpos = WIDTH - 1 - xi;
						idx = yi * ROW_BYTES + (bitpos >> 3);
						e.accepted = 1'b1;
						e.pixel = frame_mem[idx][bitpos & 7];
					end
				end
				CMD_TAKE: begin
					if (yi < HEIGHT) begin
						e.accepted = 1'b1;
						e.row_dirty = row_flag[yi];
						row_flag[yi] = 1'b0;
					end
				end
				CMD_CLEAR: begin
					foreach (frame_mem[k]) frame_mem[k] = 8'hFF;
					foreach (row_flag[k]) row_flag[k] = 1'b0;
					e.accepted = 1'b1;
				end
			endcase
			rsp_due.push_back(e);
		endfunction

		// Compare a strobed result with the oldest outstanding one.
		function void match_result(rsp_t got);
			rsp_t want;
			if (rsp_due.size() == 0) begin
				$display("%0t: result with no request outstanding: got %b", $time, got);
				mismatches++;
				return;
			end
			want = rsp_due.pop_front();
			results_checked++;
			if (got.accepted !== want.accepted) begin
				$display("%0t: accepted mismatch: expected %0b, got %0b",
					$time, want.accepted, got.accepted);
				mismatches++;
			end
			if (got.pixel !== want.pixel) begin
				$display("%0t: pixel mismatch: expected %0b, got %0b",
					$time, want.pixel, got.pixel);
				mismatches++;
			end
			if (got.row_dirty !== want.row_dirty) begin
				$display("%0t: row_dirty mismatch: expected %0b, got %0b",
					$time, want.row_dirty, got.row_dirty);
				mismatches++;
			end
		endfunction
	endclass

	frame_shadow board = new();

	int  quiet_cycles = 0;
	int  sent_by_cmd [4];
	int  clears_left;
	bit  steady;          // suppress request gaps during the no-idle stretch

	mono_framebuffer_blitter_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Results cannot be held off: grab each one in its strobe cycle.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			board.match_result(result);
	end

	// Quiet-cycle count: reset by any request or result handshake.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("%0t: watchdog expired, %0d results still outstanding",
			$time, board.rsp_due.size());
		$display("FAIL mono_framebuffer_blitter_unit");
		$finish;
	end

	function automatic req_t pack_req(logic [1:0] cmd, int x, int y, int len,
	                                  logic [23:0] pat, logic [1:0] rop, logic solid);
		req_t r;
		r.cmd = cmd;
		r.x = x[8:0];
		r.y = y[7:0];
		r.run_length = len[4:0];
		r.pattern = pat;
		r.raster_op = rop;
		r.solid_fill = solid;
		return r;
	endfunction

	// Random request. Most traffic lands on a few hot rows with well-formed runs so
	// reads see real blit results; the rest spans every field's full range.
	function automatic req_t random_request();
		req_t r;
		int   roll, y, len;
		roll = $urandom_range(0, 199);
		case ($urandom_range(0, 9))
			0: y = 0;
			1: y = HEIGHT - 1;
			2, 3: y = 1 + $urandom_range(0, 2);
			4, 5: y = HEIGHT / 2;
			6: y = $urandom_range(0, 255);
			default: y = $urandom_range(0, HEIGHT - 1);
		endcase
		r = pack_req(CMD_BLIT, 0, y, 1, 24'($urandom), ROP_OR, 1'b0);
		if (roll < 2 && clears_left > 0) begin
			clears_left--;
			r = pack_req(CMD_CLEAR, $urandom_range(0, 511), $urandom_range(0, 255),
				$urandom_range(0, 31), 24'($urandom), 2'($urandom), 1'($urandom));
		end else if (roll < 95) begin
			if ($urandom_range(0, 99) < 85) begin
				len = $urandom_range(1, MAX_RUN);
				r.run_length = len[4:0];
				r.x = 9'($urandom_range(0, WIDTH - len));
				case ($urandom_range(0, 2))
					0: r.raster_op = ROP_OR;
					1: r.raster_op = ROP_XOR;
					default: r.raster_op = ROP_ANDN;
				endcase
				r.solid_fill = ($urandom_range(0, 3) == 0);
			end else begin
				// noise: mostly rejected blits
				r = pack_req(CMD_BLIT, $urandom_range(0, 511), $urandom_range(0, 255),
					$urandom_range(0, 31), 24'($urandom), 2'($urandom), 1'($urandom));
			end
		end else if (roll < 165) begin
			r.cmd = CMD_READ;
			r.x = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
			                                  : 9'($urandom_range(0, WIDTH - 1));
			r.run_length = 5'($urandom);
			r.raster_op = 2'($urandom);
			r.solid_fill = 1'($urandom);
		end else begin
			r.cmd = CMD_TAKE;
			r.x = 9'($urandom);
			r.run_length = 5'($urandom);
			r.raster_op = 2'($urandom);
			r.solid_fill = 1'($urandom);
		end
		return r;
	endfunction

	// Present one request at the falling edge and hold it until start && !busy.
	task automatic send_request(input req_t r);
		int gap;
		gap = (!steady && $urandom_range(0, 99) < 33) ? $urandom_range(1, 12) : 0;
		repeat (gap) @(negedge clk) start <= 1'b0;
		@(negedge clk);
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy !== 1'b0);
		board.apply_request(r);
		sent_by_cmd[r.cmd]++;
	endtask

	initial begin
		start = 1'b0;
		request = '0;
		arst_n = 1'b0;
		steady = 1'b0;
		clears_left = 5;
		foreach (sent_by_cmd[i]) sent_by_cmd[i] = 0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: power-up state, edges of the row, four-byte runs, every raster op,
		// solid fill on each op, every kind of rejected request, clear screen.
		send_request(pack_req(CMD_READ, 0, 0, 0, 0, ROP_OR, 1'b0));
		send_request(pack_req(CMD_TAKE, 0, 0, 0, 0, ROP_OR, 1'b0));
		send_request(pack_req(CMD_TAKE, 0, 0, 0, 0, ROP_OR, 1'b0));
		send_request(pack_req(CMD_BLIT, 0, 0, 24, 24'h000000, ROP_ANDN, 1'b1));
		send_request(pack_req(CMD_READ, 0, 0, 0, 0, ROP_OR, 1'b0));
		send_request(pack_req(CMD_BLIT, 0, 0, 24, 24'hA5C3F0, ROP_XOR, 1'b1));
		send_request(pack_req(CMD_READ, 19, 0, 0, 0, ROP_OR, 1'b0));
		send_request(pack_req(CMD_BLIT, WIDTH - 24, HEIGHT - 1, 24, 24'hFFFFFF, ROP_OR, 1'b1));
		send_request(pack_req(CMD_BLIT, WIDTH - 24, HEIGHT - 1, 24, 24'hFFFFFF, ROP_ANDN,
			1'b0));
		send_request(pack_req(CMD_BLIT, WIDTH - 1, HEIGHT - 1, 1, 24'h000001, ROP_XOR, 1'b0));
		send_request(pack_req(CMD_READ, WIDTH - 1, HEIGHT - 1, 0, 0, ROP_OR, 1'b0));
		// unaligned 24-pixel run touches four bytes
		send_request(pack_req(CMD_BLIT, 3, 1, 24, 24'h5A5A5A, ROP_ANDN, 1'b0));
		send_request(pack_req(CMD_BLIT, 3, 1, 24, 24'h00F00F, ROP_OR, 1'b0));
		send_request(pack_req(CMD_READ, 10, 1, 0, 0, ROP_OR, 1'b0));
		// rejected blits: zero and oversized runs, past the right edge, bad row, bad op
		send_request(pack_req(CMD_BLIT, 0, 0, 0, 24'hFFFFFF, ROP_ANDN, 1'b0));
		send_request(pack_req(CMD_BLIT, 0, 0, 25, 24'hFFFFFF, ROP_ANDN, 1'b0));
		send_request(pack_req(CMD_BLIT, 511, 255, 31, 24'hFFFFFF, ROP_BAD, 1'b1));
		send_request(pack_req(CMD_BLIT, WIDTH - 10, 2, 11, 24'hFFFFFF, ROP_ANDN, 1'b0));
		send_request(pack_req(CMD_BLIT, 0, HEIGHT, 8, 24'hFFFFFF, ROP_ANDN, 1'b0));
		send_request(pack_req(CMD_BLIT, 0, 2, 8, 24'hFFFFFF, ROP_BAD, 1'b0));
		// reads and takes out of range, and a take of the last row
		send_request(pack_req(CMD_READ, WIDTH, 0, 0, 0, ROP_OR, 1'b0));
		send_request(pack_req(CMD_READ, 0, HEIGHT, 0, 0, ROP_OR, 1'b0));
		send_request(pack_req(CMD_TAKE, 0, HEIGHT - 1, 0, 0, ROP_OR, 1'b0));
		send_request(pack_req(CMD_TAKE, 0, 255, 0, 0, ROP_OR, 1'b0));
		send_request(pack_req(CMD_CLEAR, 511, 255, 31, 24'hFFFFFF, ROP_BAD, 1'b1));
		send_request(pack_req(CMD_READ, 0, 0, 0, 0, ROP_OR, 1'b0));
		send_request(pack_req(CMD_TAKE, 0, HEIGHT - 1, 0, 0, ROP_OR, 1'b0));

		// Random part; a stretch in the middle runs back to back.
		for (int n = 0; n < RANDOM_COUNT; n++) begin
			steady = (n >= 200 && n < 300);
			send_request(random_request());
		end
		@(negedge clk) start <= 1'b0;

		// Drain: every result in, then a quiet spell to catch a stray strobe.
		while (board.rsp_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d blits (%0d accepted), %0d reads, %0d takes, %0d clears;",
			sent_by_cmd[CMD_BLIT], board.blits_done, sent_by_cmd[CMD_READ],
			sent_by_cmd[CMD_TAKE], sent_by_cmd[CMD_CLEAR]);
		$display("%0d results checked, %0d mismatches.",
			board.results_checked, board.mismatches);
		if (board.mismatches == 0)
			$display("PASS mono_framebuffer_blitter_unit");
		else
			$display("FAIL mono_framebuffer_blitter_unit");
		$finish;
	end

endmodule
